@@ rtl/ist_pkg.sv @@
// Package for the INVITE server transaction controller: phase, command,
// timer and result codes, and the packed result word.
// No dependencies.
package ist_pkg;

   // Event commands carried on the request side.
   localparam logic [2:0] CMD_PEER_REQUEST  = 3'd0;
   localparam logic [2:0] CMD_PEER_ACK      = 3'd1;
   localparam logic [2:0] CMD_PEER_RESPONSE = 3'd2;
   localparam logic [2:0] CMD_TU_RESPONSE   = 3'd3;
   localparam logic [2:0] CMD_TIMER_EXPIRED = 3'd4;
   localparam logic [2:0] CMD_XMIT_FAILED   = 3'd5;

   // Timer identifiers for an expiry event.
   localparam logic [1:0] TMR_RETX    = 2'd0;
   localparam logic [1:0] TMR_FINAL   = 2'd1;
   localparam logic [1:0] TMR_CONFIRM = 2'd2;

   // Bits of the stop mask.
   localparam int STOP_G = 0;
   localparam int STOP_H = 1;
   localparam int STOP_I = 2;

   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_TRYING  = 2'd1;
   localparam logic [1:0] SEND_STORED  = 2'd2;

   localparam logic [1:0] NOTIFY_NONE    = 2'd0;
   localparam logic [1:0] NOTIFY_REQUEST = 2'd1;
   localparam logic [1:0] NOTIFY_TIMEOUT = 2'd2;
   localparam logic [1:0] NOTIFY_XMIT    = 2'd3;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_IGNORED    = 2'd1;
   localparam logic [1:0] STAT_TERMINATED = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_UNRELIABLE = 2'd0;
   localparam logic [1:0] CSR_RETX_INIT  = 2'd1;
   localparam logic [1:0] CSR_RETX_CAP   = 2'd2;

   localparam logic [15:0] RETX_INIT_RESET = 16'd500;
   localparam logic [15:0] RETX_CAP_RESET  = 16'd4000;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_PROCEEDING = 3'd1,
      PH_COMPLETED  = 3'd2,
      PH_CONFIRMED  = 3'd3,
      PH_TERMINATED = 3'd4
   } phase_type;

   // Result word; the last member sits in the lowest bits.
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  phase;
      logic [2:0]  stop_timers;
      logic        start_confirm_timer;
      logic        start_final_timer;
      logic [15:0] retx_duration;
      logic        start_retx_timer;
      logic [1:0]  notify_tu;
      logic [1:0]  send_kind;
   } result_type;

endpackage

@@ rtl/invite_server_transaction_fsm_core.sv @@
// Top level of the INVITE server transaction controller: event decode,
// transaction state and a two-word result buffer.
// Depends on ist_pkg.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_tvalid/req_tready  tuser: command; tdata: code, timer, failure
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: one action word per event
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// One event is accepted per cycle when req_tready is high; its action word is registered.
// The decision is a single combinational pass from the phase and timer flags.
// A result plus one skid word are held when rsp_tready is low; req_tready
// drops only when both are full. Configuration writes are always ready.
// Reset is synchronous and returns the transaction to idle with defaults.
module invite_server_transaction_fsm_core
   import ist_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] command
   input  logic [15:0] req_tdata,   // [9:0] response_code, [11:10] timer_kind,
                                    // [12] send_failed, [15:13] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] send_kind, [3:2] notify_tu,
                                    // [4] start_retx_timer, [20:5] retx_duration,
                                    // [21] start_final_timer, [22] start_confirm_timer,
                                    // [25:23] stop_timers, [28:26] phase,
                                    // [30:29] status, [31] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic        unreliable_ff;
   logic [15:0] retx_init_ff;
   logic [15:0] retx_cap_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] interval_ff, interval_in;
   logic        g_run_ff, g_run_in;
   logic        h_run_ff, h_run_in;
   logic        i_run_ff, i_run_in;

   result_type  out_ff, out_in;
   result_type  skid_ff;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff;

   logic        req_fire;
   logic        rsp_fire;
   result_type  res;

   logic [2:0]  cmd;
   logic [9:0]  code;
   logic [1:0]  tkind;
   logic        failed;
   logic [15:0] cap;
   logic [16:0] doubled;
   logic [15:0] next_interval;

   assign cmd    = req_tuser;
   assign code   = req_tdata[9:0];
   assign tkind  = req_tdata[11:10];
   assign failed = req_tdata[12];

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         unreliable_ff <= 1'b1;
         retx_init_ff  <= RETX_INIT_RESET;
         retx_cap_ff   <= RETX_CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UNRELIABLE: unreliable_ff <= csr_data[0];
            CSR_RETX_INIT:  retx_init_ff  <= csr_data;
            CSR_RETX_CAP:   retx_cap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Doubled retransmit interval, limited by the cap and never zero.
   always_comb begin
      cap     = (retx_cap_ff == '0) ? 16'd1 : retx_cap_ff;
      doubled = {interval_ff, 1'b0};
      if (doubled > {1'b0, cap}) begin
         next_interval = cap;
      end else begin
         next_interval = doubled[15:0];
      end
      if (next_interval == '0) begin
         next_interval = 16'd1;
      end
   end

   // Event decode and next transaction state.
   always_comb begin
      res         = '0;
      phase_in    = phase_ff;
      interval_in = interval_ff;
      g_run_in    = g_run_ff;
      h_run_in    = h_run_ff;
      i_run_in    = i_run_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd == CMD_PEER_REQUEST) begin
               interval_in   = (retx_init_ff == '0) ? 16'd1 : retx_init_ff;
               phase_in      = PH_PROCEEDING;
               res.send_kind = SEND_TRYING;
               res.notify_tu = NOTIFY_REQUEST;
            end else begin
               res.status = STAT_IGNORED;
            end
         end
         PH_PROCEEDING: begin
            if (cmd == CMD_PEER_REQUEST) begin
               res.send_kind = SEND_STORED;
            end else if (cmd == CMD_TU_RESPONSE) begin
               res.send_kind = SEND_STORED;
               if (code inside {[10'd100:10'd199]}) begin
                  // Provisional response: the phase is kept.
               end else if (code inside {[10'd200:10'd299]}) begin
                  res.stop_timers = {i_run_ff, h_run_ff, g_run_ff};
                  g_run_in = 1'b0;
                  h_run_in = 1'b0;
                  i_run_in = 1'b0;
                  phase_in = PH_TERMINATED;
               end else begin
                  res.start_final_timer = 1'b1;
                  h_run_in = 1'b1;
                  if (unreliable_ff) begin
                     res.start_retx_timer = 1'b1;
                     res.retx_duration = (interval_ff == '0) ? 16'd1 : interval_ff;
                     g_run_in = 1'b1;
                  end
                  phase_in = PH_COMPLETED;
               end
            end else if (cmd == CMD_XMIT_FAILED) begin
               res.notify_tu   = NOTIFY_XMIT;
               res.stop_timers = {i_run_ff, h_run_ff, g_run_ff};
               g_run_in = 1'b0;
               h_run_in = 1'b0;
               i_run_in = 1'b0;
               phase_in = PH_TERMINATED;
            end else begin
               res.status = STAT_IGNORED;
            end
         end
         PH_COMPLETED: begin
            if (cmd == CMD_PEER_REQUEST) begin
               res.send_kind = SEND_STORED;
            end else if (cmd == CMD_PEER_ACK) begin
               res.stop_timers = {1'b0, h_run_ff, g_run_ff};
               g_run_in = 1'b0;
               h_run_in = 1'b0;
               if (unreliable_ff) begin
                  res.start_confirm_timer = 1'b1;
                  i_run_in = 1'b1;
                  phase_in = PH_CONFIRMED;
               end else begin
                  res.stop_timers[STOP_I] = i_run_ff;
                  i_run_in = 1'b0;
                  phase_in = PH_TERMINATED;
               end
            end else if (cmd == CMD_TIMER_EXPIRED && tkind == TMR_RETX && g_run_ff) begin
               g_run_in = 1'b0;
               if (failed) begin
                  res.notify_tu   = NOTIFY_XMIT;
                  res.stop_timers = {i_run_ff, h_run_ff, 1'b0};
                  h_run_in = 1'b0;
                  i_run_in = 1'b0;
                  phase_in = PH_TERMINATED;
               end else begin
                  res.send_kind = SEND_STORED;
                  if (unreliable_ff) begin
                     interval_in          = next_interval;
                     res.start_retx_timer = 1'b1;
                     res.retx_duration    = next_interval;
                     g_run_in             = 1'b1;
                  end
               end
            end else if (cmd == CMD_TIMER_EXPIRED && tkind == TMR_FINAL && h_run_ff) begin
               res.notify_tu   = NOTIFY_TIMEOUT;
               res.stop_timers = {i_run_ff, 1'b0, g_run_ff};
               g_run_in = 1'b0;
               h_run_in = 1'b0;
               i_run_in = 1'b0;
               phase_in = PH_TERMINATED;
            end else if (cmd == CMD_XMIT_FAILED) begin
               res.notify_tu   = NOTIFY_XMIT;
               res.stop_timers = {i_run_ff, h_run_ff, g_run_ff};
               g_run_in = 1'b0;
               h_run_in = 1'b0;
               i_run_in = 1'b0;
               phase_in = PH_TERMINATED;
            end else begin
               res.status = STAT_IGNORED;
            end
         end
         PH_CONFIRMED: begin
            if (cmd == CMD_TIMER_EXPIRED && tkind == TMR_CONFIRM && i_run_ff) begin
               res.stop_timers = {1'b0, h_run_ff, g_run_ff};
               g_run_in = 1'b0;
               h_run_in = 1'b0;
               i_run_in = 1'b0;
               phase_in = PH_TERMINATED;
            end else begin
               res.status = STAT_IGNORED;
            end
         end
         default: begin
            phase_in   = PH_TERMINATED;
            res.status = STAT_TERMINATED;
         end
      endcase

      res.phase = phase_in;
   end

   // Transaction state advances only on an accepted event.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         interval_ff <= '0;
         g_run_ff    <= 1'b0;
         h_run_ff    <= 1'b0;
         i_run_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         interval_ff <= interval_in;
         g_run_ff    <= g_run_in;
         h_run_ff    <= h_run_in;
         i_run_ff    <= i_run_in;
      end
   end

   // Output word and skid word. The skid word fills only while the output
   // word is stalled, and it drains into the output word first.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (!out_valid_ff || rsp_fire) begin
         out_valid_in = skid_valid_ff || req_fire;
         out_in       = skid_valid_ff ? skid_ff : res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (!out_valid_ff || rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end else if (req_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (out_valid_ff && !rsp_fire && req_fire) begin
         skid_ff <= res;
      end
   end

   // Timer G only runs while the final response is being retransmitted.
   assert property (@(posedge clock) disable iff (reset)
      g_run_ff |-> phase_ff == PH_COMPLETED)
      else $error("retransmit timer running outside the completed phase");

   // Timer I only runs in the confirmed phase.
   assert property (@(posedge clock) disable iff (reset)
      i_run_ff |-> phase_ff == PH_CONFIRMED)
      else $error("confirm timer running outside the confirmed phase");

   // Terminated holds until reset.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TERMINATED |=> phase_ff == PH_TERMINATED)
      else $error("transaction left the terminated phase");

   // The skid word is only occupied behind a stalled output word.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff && $past(out_valid_ff && !rsp_tready))
      else $error("skid word filled without a stalled output word");

   // A retransmit start always carries a nonzero duration, and none otherwise.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.start_retx_timer == (out_ff.retx_duration != '0)))
      else $error("retransmit duration does not match the timer start");

endmodule

@@ tb/sv/invite_server_transaction_fsm_core_tb.sv @@
// Self-checking bench for the INVITE server transaction controller: drives event words with
// random bursts and stalls, predicts each action word and checks it field by field.
// Depends on ist_pkg and invite_server_transaction_fsm_core.
`timescale 1ns / 100ps

module invite_server_transaction_fsm_core_tb;
   import ist_pkg::*;

   // Command and timer codes that the block must ignore.
   localparam logic [2:0] CMD_UNDEFINED_A = 3'd6;
   localparam logic [2:0] CMD_UNDEFINED_B = 3'd7;
   localparam logic [1:0] TMR_UNDEFINED   = 2'd3;
   localparam int         STALL_LIMIT     = 3000;
   localparam int         HOLD_AFTER      = 500;
   localparam int         HOLD_CYCLES     = 180;

   typedef struct packed {
      logic [2:0] command;
      logic [9:0] code;
      logic [1:0] timer;
      logic       failed;
   } sip_event_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   invite_server_transaction_fsm_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the transaction state and configuration.
   logic        cfg_unreliable = 1'b1;
   logic [15:0] cfg_retx_init  = RETX_INIT_RESET;
   logic [15:0] cfg_retx_cap   = RETX_CAP_RESET;
   phase_type   txn_phase      = PH_IDLE;
   logic [15:0] retx_ms        = '0;
   logic        g_running      = 1'b0;
   logic        h_running      = 1'b0;
   logic        i_running      = 1'b0;

   sip_event_type pending_events[$];
   result_type  expected_actions[$];
   sip_event_type on_bus;
   result_type  predicted;
   int          error_count    = 0;
   int          items_accepted = 0;
   int          burst_left     = 0;
   int          gap_left       = 0;
   int          idle_cycles    = 0;
   int          hold_left      = 0;
   logic        hold_done      = 1'b0;
   int          stall_mode     = 0;
   int          mode_left      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every timer still running is reported as stopped.
   task automatic close_transaction(inout logic [2:0] stop);
      stop      = stop | {i_running, h_running, g_running};
      g_running = 1'b0;
      h_running = 1'b0;
      i_running = 1'b0;
      txn_phase = PH_TERMINATED;
   endtask

   task automatic advance_transaction(input sip_event_type ev, output result_type act);
      logic [15:0] cap;
      logic [16:0] doubled;
      act = '0;
      cap = (cfg_retx_cap == 16'd0) ? 16'd1 : cfg_retx_cap;
      case (txn_phase)
         PH_IDLE: begin
            if (ev.command == CMD_PEER_REQUEST) begin
               retx_ms       = (cfg_retx_init == 16'd0) ? 16'd1 : cfg_retx_init;
               txn_phase     = PH_PROCEEDING;
               act.send_kind = SEND_TRYING;
               act.notify_tu = NOTIFY_REQUEST;
            end else begin
               act.status = STAT_IGNORED;
            end
         end
         PH_PROCEEDING: begin
            if (ev.command == CMD_PEER_REQUEST) begin
               act.send_kind = SEND_STORED;
            end else if (ev.command == CMD_TU_RESPONSE) begin
               act.send_kind = SEND_STORED;
               if (ev.code >= 10'd200 && ev.code < 10'd300) begin
                  close_transaction(act.stop_timers);
               end else if (ev.code < 10'd100 || ev.code >= 10'd200) begin
                  // Anything but a provisional code is a final response.
                  act.start_final_timer = 1'b1;
                  h_running             = 1'b1;
                  if (cfg_unreliable) begin
                     act.start_retx_timer = 1'b1;
                     act.retx_duration    = (retx_ms == 16'd0) ? 16'd1 : retx_ms;
                     g_running            = 1'b1;
                  end
                  txn_phase = PH_COMPLETED;
               end
            end else if (ev.command == CMD_XMIT_FAILED) begin
               act.notify_tu = NOTIFY_XMIT;
               close_transaction(act.stop_timers);
            end else begin
               act.status = STAT_IGNORED;
            end
         end
         PH_COMPLETED: begin
            if (ev.command == CMD_PEER_REQUEST) begin
               act.send_kind = SEND_STORED;
            end else if (ev.command == CMD_PEER_ACK) begin
               act.stop_timers = {1'b0, h_running, g_running};
               g_running       = 1'b0;
               h_running       = 1'b0;
               if (cfg_unreliable) begin
                  act.start_confirm_timer = 1'b1;
                  i_running               = 1'b1;
                  txn_phase               = PH_CONFIRMED;
               end else begin
                  close_transaction(act.stop_timers);
               end
            end else if (ev.command == CMD_TIMER_EXPIRED && ev.timer == TMR_RETX && g_running) begin
               g_running = 1'b0;
               if (ev.failed) begin
                  act.notify_tu = NOTIFY_XMIT;
                  close_transaction(act.stop_timers);
               end else begin
                  act.send_kind = SEND_STORED;
                  if (cfg_unreliable) begin
                     doubled = {retx_ms, 1'b0};
                     if (doubled > {1'b0, cap}) doubled = {1'b0, cap};
                     if (doubled == 17'd0) doubled = 17'd1;
                     retx_ms              = doubled[15:0];
                     act.start_retx_timer = 1'b1;
                     act.retx_duration    = retx_ms;
                     g_running            = 1'b1;
                  end
               end
            end else if (ev.command == CMD_TIMER_EXPIRED && ev.timer == TMR_FINAL && h_running) begin
               h_running     = 1'b0;
               act.notify_tu = NOTIFY_TIMEOUT;
               close_transaction(act.stop_timers);
            end else if (ev.command == CMD_XMIT_FAILED) begin
               act.notify_tu = NOTIFY_XMIT;
               close_transaction(act.stop_timers);
            end else begin
               act.status = STAT_IGNORED;
            end
         end
         PH_CONFIRMED: begin
            if (ev.command == CMD_TIMER_EXPIRED && ev.timer == TMR_CONFIRM && i_running) begin
               i_running = 1'b0;
               close_transaction(act.stop_timers);
            end else begin
               act.status = STAT_IGNORED;
            end
         end
         default: begin
            txn_phase  = PH_TERMINATED;
            act.status = STAT_TERMINATED;
         end
      endcase
      act.phase = txn_phase;
   endtask

   function automatic sip_event_type random_event(input logic [2:0] cmd);
      sip_event_type ev;
      ev.command = cmd;
      ev.code    = 10'($urandom_range(0, 1023));
      ev.timer   = 2'($urandom_range(0, 3));
      ev.failed  = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   // Mostly events that keep the current phase, so that the run stays deep in it.
   function automatic sip_event_type pick_event(input phase_type ph);
      sip_event_type ev;
      int unsigned r;
      r  = $urandom_range(0, 99);
      ev = random_event(3'($urandom_range(0, 7)));
      case (ph)
         PH_PROCEEDING: begin
            if (r < 20) begin
               ev.command = CMD_PEER_REQUEST;
            end else if (r < 45) begin
               ev.command = CMD_TU_RESPONSE;
               ev.code    = 10'($urandom_range(100, 199));
            end else if (r < 60) begin
               ev.command = (r < 52) ? CMD_PEER_ACK : CMD_PEER_RESPONSE;
            end else if (r < 80) begin
               ev.command = CMD_TIMER_EXPIRED;
            end else begin
               ev.command = $urandom_range(0, 1) ? CMD_UNDEFINED_A : CMD_UNDEFINED_B;
            end
         end
         PH_COMPLETED: begin
            if (r < 15) begin
               ev.command = CMD_PEER_REQUEST;
            end else if (r < 55) begin
               ev.command = CMD_TIMER_EXPIRED;
               ev.timer   = TMR_RETX;
               ev.failed  = 1'b0;
            end else if (r < 65) begin
               ev.command = CMD_PEER_RESPONSE;
            end else if (r < 75) begin
               ev.command = CMD_TU_RESPONSE;
            end else if (r < 85) begin
               ev.command = CMD_TIMER_EXPIRED;
               ev.timer   = $urandom_range(0, 1) ? TMR_CONFIRM : TMR_UNDEFINED;
            end else begin
               ev.command = $urandom_range(0, 1) ? CMD_UNDEFINED_A : CMD_UNDEFINED_B;
            end
         end
         PH_CONFIRMED: begin
            if (ev.command == CMD_TIMER_EXPIRED && ev.timer == TMR_CONFIRM)
               ev.timer = TMR_UNDEFINED;
         end
         default: ;
      endcase
      return ev;
   endfunction

   function automatic logic [15:0] pick_interval();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'hFFFF;
         4: return 16'($urandom_range(1, 1000));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_UNRELIABLE: cfg_unreliable = value[0];
         CSR_RETX_INIT:  cfg_retx_init  = value;
         CSR_RETX_CAP:   cfg_retx_cap   = value;
         default: ;
      endcase
   endtask

   // Checked at the falling edge, once the clocked processes have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_actions.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_batch(input int count);
      for (int n = 0; n < count; n++)
         pending_events.push_back(pick_event(txn_phase));
      wait_drained();
   endtask

   task automatic send_one(input sip_event_type ev);
      pending_events.push_back(ev);
      wait_drained();
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Driver: offers queued event words in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_transaction(on_bus, predicted);
            expected_actions.push_back(predicted);
            items_accepted <= items_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               on_bus     = pending_events.pop_front();
               req_tuser  <= on_bus.command;
               req_tdata  <= {3'b000, on_bus.failed, on_bus.timer, on_bus.code};
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                            : $urandom_range(0, 4);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off that fills the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: every action word must match the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_actions.size() == 0) begin
            error_count++;
            if (error_count <= 40)
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = expected_actions.pop_front();
            got  = result_type'(rsp_tdata[30:0]);
            check_field("send_kind", want.send_kind, got.send_kind);
            check_field("notify_tu", want.notify_tu, got.notify_tu);
            check_field("start_retx_timer", want.start_retx_timer, got.start_retx_timer);
            check_field("retx_duration", want.retx_duration, got.retx_duration);
            check_field("start_final_timer", want.start_final_timer, got.start_final_timer);
            check_field("start_confirm_timer", want.start_confirm_timer,
                        got.start_confirm_timer);
            check_field("stop_timers", want.stop_timers, got.stop_timers);
            check_field("phase", want.phase, got.phase);
            check_field("status", want.status, got.status);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int          r;
      logic [9:0]  final_code;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Idle: everything except a request is ignored.
      pending_events.push_back(random_event(CMD_PEER_ACK));
      pending_events.push_back(random_event(CMD_PEER_RESPONSE));
      pending_events.push_back('{CMD_TU_RESPONSE, 10'd200, TMR_RETX, 1'b0});
      pending_events.push_back('{CMD_TIMER_EXPIRED, 10'd0, TMR_RETX, 1'b0});
      pending_events.push_back('{CMD_TIMER_EXPIRED, 10'd1023, TMR_UNDEFINED, 1'b1});
      pending_events.push_back(random_event(CMD_XMIT_FAILED));
      pending_events.push_back(random_event(CMD_UNDEFINED_A));
      pending_events.push_back(random_event(CMD_UNDEFINED_B));
      wait_drained();

      csr_write(CSR_UNRELIABLE, 16'd0);
      csr_write(CSR_UNRELIABLE, 16'd1);
      csr_write(CSR_RETX_INIT, pick_interval());
      csr_write(CSR_RETX_CAP, pick_interval());

      // Request, retransmitted request, ignored events and provisional responses.
      pending_events.push_back(random_event(CMD_PEER_REQUEST));
      pending_events.push_back(random_event(CMD_PEER_REQUEST));
      pending_events.push_back(random_event(CMD_PEER_ACK));
      pending_events.push_back(random_event(CMD_PEER_RESPONSE));
      pending_events.push_back('{CMD_TIMER_EXPIRED, 10'd0, TMR_RETX, 1'b1});
      pending_events.push_back('{CMD_TIMER_EXPIRED, 10'd0, TMR_FINAL, 1'b0});
      pending_events.push_back(random_event(CMD_UNDEFINED_A));
      pending_events.push_back('{CMD_TU_RESPONSE, 10'd100, TMR_RETX, 1'b0});
      pending_events.push_back('{CMD_TU_RESPONSE, 10'd199, TMR_UNDEFINED, 1'b1});
      pending_events.push_back('{CMD_UNDEFINED_B, 10'd1023, TMR_UNDEFINED, 1'b1});
      wait_drained();
      run_batch(300);

      // Leave proceeding: usually by a final response, sometimes by a 2xx or a failure.
      csr_write(CSR_UNRELIABLE, 16'($urandom_range(0, 7) != 0));
      r = $urandom_range(0, 99);
      if (r < 80) begin
         case ($urandom_range(0, 6))
            0:       final_code = 10'd300;
            1:       final_code = 10'd699;
            2:       final_code = 10'd0;
            3:       final_code = 10'd99;
            4:       final_code = 10'd700;
            5:       final_code = 10'd1023;
            default: final_code = 10'($urandom_range(300, 699));
         endcase
         send_one('{CMD_TU_RESPONSE, final_code, 2'($urandom_range(0, 3)), 1'b0});
      end else if (r < 90) begin
         send_one('{CMD_TU_RESPONSE, 10'($urandom_range(200, 299)), TMR_RETX, 1'b0});
      end else begin
         send_one(random_event(CMD_XMIT_FAILED));
      end

      // Completed: retransmissions under changing caps.
      for (int b = 0; b < 8 && txn_phase == PH_COMPLETED; b++) begin
         csr_write(CSR_RETX_CAP, pick_interval());
         if (b == 3) csr_write(CSR_RETX_INIT, pick_interval());
         if (b == 7) csr_write(CSR_UNRELIABLE, 16'($urandom_range(0, 1)));
         run_batch(130);
      end

      if (txn_phase == PH_COMPLETED) begin
         case ($urandom_range(0, 3))
            0: begin
               csr_write(CSR_UNRELIABLE, 16'($urandom_range(0, 1)));
               send_one(random_event(CMD_PEER_ACK));
            end
            1: send_one('{CMD_TIMER_EXPIRED, 10'($urandom_range(0, 1023)), TMR_FINAL, 1'b0});
            2: send_one('{CMD_TIMER_EXPIRED, 10'($urandom_range(0, 1023)), TMR_RETX, 1'b1});
            default: send_one(random_event(CMD_XMIT_FAILED));
         endcase
         // A failed retransmission is ignored when G is not running.
         if (txn_phase == PH_COMPLETED) send_one(random_event(CMD_PEER_ACK));
      end

      if (txn_phase == PH_CONFIRMED) begin
         run_batch(200);
         send_one('{CMD_TIMER_EXPIRED, 10'($urandom_range(0, 1023)), TMR_CONFIRM, 1'b0});
      end

      // Terminated holds for anything; this batch tops the run up to about 2000 words.
      run_batch((items_accepted < 1700) ? 2000 - items_accepted : 300);

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_actions.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ist_pkg.sv
rtl/invite_server_transaction_fsm_core.sv
tb/sv/invite_server_transaction_fsm_core_tb.sv
